// ----- design/abd_pkg.sv -----
// Shared types, constants and helper functions of the anchor box delta decoder.
package abd_pkg;

  // Default number of fraction bits of the box and delta values.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_W = 2'd3;
  localparam logic [31:0] INV_Y_RST = 32'd6554;
  localparam logic [31:0] INV_X_RST = 32'd6554;
  localparam logic [31:0] INV_H_RST = 32'd13107;
  localparam logic [31:0] INV_W_RST = 32'd13107;

  // log2(e) and the 2^f polynomial, all with 30 fraction bits.
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [30:0] P5_Q30 = 31'd1431680;
  localparam logic [30:0] HORNER_C [0:4] = '{
    31'd10327387, 31'd59597083, 31'd257941248, 31'd744261118, 31'd1073741824
  };

  // Largest positive 31-bit magnitude, used when exp overflows.
  localparam logic [30:0] EXP_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_h;
    logic signed [31:0] delta_w;
    logic signed [31:0] anchor_top;
    logic signed [31:0] anchor_left;
    logic signed [31:0] anchor_bottom;
    logic signed [31:0] anchor_right;
  } abd_in_t;

  typedef struct packed {
    logic signed [31:0] box_top;
    logic signed [31:0] box_left;
    logic signed [31:0] box_bottom;
    logic signed [31:0] box_right;
    logic               saturated;
  } abd_out_t;

  // Clips a wide signed value to 32 bits; the top bit of the result flags a clip.
  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -72'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // One Horner step of the 2^f polynomial: c + (p * f) >> 30.
  function automatic logic [30:0] horner_step(input logic [30:0] c, input logic [30:0] p,
                                              input logic [29:0] f);
    logic [60:0] prod;
    prod = 61'(p) * 61'(f);
    return c + prod[60:30];
  endfunction

endpackage

// ----- design/anchor_box_delta_decoder.sv -----
// Top level of the anchor box delta decoder: an eleven-stage streaming pipeline.
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_stall  | abd_pkg::abd_in_t
//   out_     | output    | out_valid / out_stall| abd_pkg::abd_out_t
//   cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One box enters per cycle while the output is not stalled; the exp
// polynomial, one Horner multiply per stage, sets the depth.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and requests are taken while a result waits.
// Synchronous reset clears the valid bits and loads the scale registers' reset values.
// The configuration port is always ready.
module anchor_box_delta_decoder #(
  parameter int FRAC_BITS = abd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  abd_pkg::abd_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output abd_pkg::abd_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int NS = 11;
  localparam int NSH_BASE = 30 - FRAC_BITS;

  logic [31:0] inv_r [0:3];
  logic [NS:1] valid_r;
  logic [NS:1] en;
  logic [NS:1] valid_in;

  // Stage registers; where an array runs over stages, its index is the stage that writes it.
  logic signed [64:0] prod_r [0:3];
  logic signed [32:0] ah_r [1:9];
  logic signed [32:0] aw_r [1:9];
  logic signed [32:0] cy_r [1:3];
  logic signed [32:0] cx_r [1:3];
  logic signed [31:0] d_r [0:3];
  logic               sat_r [2:10];
  logic signed [63:0] t_r [0:1];
  logic signed [64:0] ym_r;
  logic signed [64:0] xm_r;
  logic signed [65:0] yc_r [4:10];
  logic signed [65:0] xc_r [4:10];
  logic signed [31:0] k_r [4:8][0:1];
  logic [29:0]        f_r [4:7][0:1];
  logic [30:0]        p_r [4:8][0:1];
  logic [30:0]        e_r [0:1];
  logic signed [64:0] bp_r [0:1];
  abd_pkg::abd_out_t  out_r;

  // Combinational helpers.
  logic signed [31:0] delta_c [0:3];
  logic [32:0]        dclip [0:3];
  logic signed [31:0] k_c [0:1];
  logic [29:0]        f_c [0:1];
  logic signed [33:0] nsh [0:1];
  logic [30:0]        e_c [0:1];
  logic               esat [0:1];
  logic signed [64:0] hh [0:1];
  logic [32:0]        oclip [0:3];
  abd_pkg::abd_out_t  out_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~en[1];
  assign out_valid = valid_r[NS];
  assign out_data  = out_r;
  assign valid_in  = {valid_r[NS-1:1], in_valid};

  // Stall chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[NS] = ~valid_r[NS] | ~out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = ~valid_r[k] | en[k+1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) valid_r[k] <= valid_in[k];
      end
    end
  end

  // Scale registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r[0] <= abd_pkg::INV_Y_RST;
      inv_r[1] <= abd_pkg::INV_X_RST;
      inv_r[2] <= abd_pkg::INV_H_RST;
      inv_r[3] <= abd_pkg::INV_W_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abd_pkg::CFG_INV_Y: inv_r[0] <= cfg_data;
        abd_pkg::CFG_INV_X: inv_r[1] <= cfg_data;
        abd_pkg::CFG_INV_H: inv_r[2] <= cfg_data;
        abd_pkg::CFG_INV_W: inv_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Combinational logic between the stages.
  always_comb begin
    delta_c[0] = in_data.delta_y;
    delta_c[1] = in_data.delta_x;
    delta_c[2] = in_data.delta_h;
    delta_c[3] = in_data.delta_w;
    for (int i = 0; i < 4; i++) begin
      dclip[i] = abd_pkg::sat32(72'(prod_r[i] >>> FRAC_BITS));
    end
    // Split log2 of the size delta into integer and fraction.
    for (int l = 0; l < 2; l++) begin
      k_c[l] = 32'(t_r[l] >>> (FRAC_BITS + 30));
      f_c[l] = t_r[l][FRAC_BITS+29:FRAC_BITS];
    end
    // Scale the mantissa by 2^k with overflow clip.
    for (int l = 0; l < 2; l++) begin
      nsh[l] = 34'(NSH_BASE) - 34'(k_r[8][l]);
      esat[l] = 1'b0;
      if (nsh[l] < 0) begin
        e_c[l] = abd_pkg::EXP_MAX;
        esat[l] = 1'b1;
      end else if (nsh[l] > 34'sd30) begin
        e_c[l] = '0;
      end else begin
        e_c[l] = p_r[8][l] >> nsh[l][4:0];
      end
    end
    // Corners from center and half size.
    for (int l = 0; l < 2; l++) begin
      hh[l] = bp_r[l] >>> (FRAC_BITS + 1);
    end
    oclip[0] = abd_pkg::sat32(72'(68'(yc_r[10]) - 68'(hh[0])));
    oclip[1] = abd_pkg::sat32(72'(68'(xc_r[10]) - 68'(hh[1])));
    oclip[2] = abd_pkg::sat32(72'(68'(yc_r[10]) + 68'(hh[0])));
    oclip[3] = abd_pkg::sat32(72'(68'(xc_r[10]) + 68'(hh[1])));
    out_nxt.box_top    = oclip[0][31:0];
    out_nxt.box_left   = oclip[1][31:0];
    out_nxt.box_bottom = oclip[2][31:0];
    out_nxt.box_right  = oclip[3][31:0];
    out_nxt.saturated  = sat_r[10] | oclip[0][32] | oclip[1][32] | oclip[2][32]
                         | oclip[3][32];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Stage 1: delta times reciprocal, anchor size and center.
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= delta_c[i] * $signed({1'b0, inv_r[i]});
      end
      ah_r[1] <= 33'(in_data.anchor_bottom) - 33'(in_data.anchor_top);
      aw_r[1] <= 33'(in_data.anchor_right) - 33'(in_data.anchor_left);
      cy_r[1] <= (33'(in_data.anchor_top) + 33'(in_data.anchor_bottom)) >>> 1;
      cx_r[1] <= (33'(in_data.anchor_left) + 33'(in_data.anchor_right)) >>> 1;
    end
    // Stage 2: rescale and clip the deltas.
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        d_r[i] <= dclip[i][31:0];
      end
      sat_r[2] <= dclip[0][32] | dclip[1][32] | dclip[2][32] | dclip[3][32];
    end
    // Stage 3: size deltas to base 2, center offsets times anchor size.
    if (en[3]) begin
      t_r[0] <= d_r[2] * $signed(abd_pkg::LOG2E_Q30);
      t_r[1] <= d_r[3] * $signed(abd_pkg::LOG2E_Q30);
      ym_r   <= d_r[0] * ah_r[2];
      xm_r   <= d_r[1] * aw_r[2];
    end
    // Stage 4: first Horner step and the box center.
    if (en[4]) begin
      for (int l = 0; l < 2; l++) begin
        k_r[4][l] <= k_c[l];
        f_r[4][l] <= f_c[l];
        p_r[4][l] <= abd_pkg::horner_step(abd_pkg::HORNER_C[0], abd_pkg::P5_Q30, f_c[l]);
      end
      yc_r[4] <= 66'(ym_r >>> FRAC_BITS) + 66'(cy_r[3]);
      xc_r[4] <= 66'(xm_r >>> FRAC_BITS) + 66'(cx_r[3]);
    end
    // Stages 5 to 8: remaining Horner steps.
    for (int s = 5; s <= 8; s++) begin
      if (en[s]) begin
        for (int l = 0; l < 2; l++) begin
          k_r[s][l] <= k_r[s-1][l];
          p_r[s][l] <= abd_pkg::horner_step(abd_pkg::HORNER_C[s-4], p_r[s-1][l],
                                            f_r[s-1][l]);
        end
      end
    end
    for (int s = 5; s <= 7; s++) begin
      if (en[s]) begin
        for (int l = 0; l < 2; l++) begin
          f_r[s][l] <= f_r[s-1][l];
        end
      end
    end
    // Stage 9: exp value.
    if (en[9]) begin
      e_r[0] <= e_c[0];
      e_r[1] <= e_c[1];
    end
    // Stage 10: box size.
    if (en[10]) begin
      bp_r[0] <= $signed({1'b0, e_r[0]}) * ah_r[9];
      bp_r[1] <= $signed({1'b0, e_r[1]}) * aw_r[9];
    end
    // Stage 11: output register.
    if (en[11]) out_r <= out_nxt;
    // Values carried along the pipe.
    for (int s = 2; s <= 9; s++) begin
      if (en[s]) begin
        ah_r[s] <= ah_r[s-1];
        aw_r[s] <= aw_r[s-1];
      end
    end
    for (int s = 2; s <= 3; s++) begin
      if (en[s]) begin
        cy_r[s] <= cy_r[s-1];
        cx_r[s] <= cx_r[s-1];
      end
    end
    for (int s = 5; s <= 10; s++) begin
      if (en[s]) begin
        yc_r[s] <= yc_r[s-1];
        xc_r[s] <= xc_r[s-1];
      end
    end
    for (int s = 3; s <= 10; s++) begin
      if (en[s]) begin
        if (s == 9) sat_r[s] <= sat_r[s-1] | esat[0] | esat[1];
        else sat_r[s] <= sat_r[s-1];
      end
    end
  end

endmodule

// ----- design/abd_check.sv -----
// Port-level assertions for the anchor box delta decoder, bound to its top level.
module abd_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input abd_pkg::abd_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side only backs up when the whole pipe is full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A held result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("held result dropped");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("held result changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind anchor_box_delta_decoder abd_check u_abd_check (.*);
